// ----- hdl/bar_pkg.sv -----
package bar_pkg;

   localparam int NUM_TIDS    = 16;
   localparam int MAX_WINDOW  = 64;
   localparam int HANDLE_BITS = 10;

   localparam int SEQ_BITS    = 12;
   localparam int TID_W       = 4;
   localparam int WIN_W       = 7;
   localparam int TID_BITS    = (NUM_TIDS > 1) ? $clog2(NUM_TIDS) : 1;
   // MAX_WINDOW is kept a power of two so that a slot is the low bits of seq.
   localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
   localparam int SLOT_ADDR_W = TID_BITS + SLOT_BITS;
   localparam int SLOT_DEPTH  = NUM_TIDS * MAX_WINDOW;
   localparam int WIN_RESET   = 64;

   localparam logic KIND_FRAME   = 1'b0;
   localparam logic KIND_SESSION = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [TID_W-1:0]       tid;
      logic [SEQ_BITS-1:0]    seq;
      logic [HANDLE_BITS-1:0] frame_handle;
      logic                   forward;
   } req_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] out_handle;
      logic [TID_W-1:0]       out_tid;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0]   next_seq;
      logic [MAX_WINDOW-1:0] slot_valid;
   } ctx_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic                   forward;
   } slot_type;

endpackage

// ----- hdl/block_ack_reorder_buffer_core.sv -----
// A session start leaves busy low; a dropped or held frame keeps it high through ST_CTX,
// a frame past the window through ST_CTX and ST_FLUSH, and an in-order frame through ST_CTX,
// a ST_DRAIN and ST_SLOT pair per held frame drained, a last ST_DRAIN and ST_FLUSH. One item
// at a time; busy stays high while the drain walks the slot memory, read once per held frame.
// Results are registered strobes one cycle wide; the receiver cannot stall them.
// Reset is synchronous: all contexts read as fresh sessions and the window returns to 64.
module block_ack_reorder_buffer_core
   import bar_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req,
   output logic             rsp_strobe,
   output rsp_type          rsp,
   input  logic             csr_we,
   input  logic [WIN_W-1:0] csr_wdata
);

   // One-hot sequencer. The context of a TID is read, evaluated, optionally
   // drained slot by slot, and written back if it changed, before the next item is taken.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CTX   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_SLOT  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Per-TID context memory (next sequence number and held-slot bitmap). An
   // entry whose valid flop is clear reads as a fresh session.
   ctx_type ctx_mem [NUM_TIDS];
   ctx_type ctx_q_ff;
   logic [NUM_TIDS-1:0] ctx_valid_ff, ctx_valid_in;
   logic    ctx_we;
   ctx_type ctx_wdata;

   // Held-frame memory, one row of MAX_WINDOW slots per TID.
   slot_type slot_mem [SLOT_DEPTH];
   slot_type slot_q_ff;
   logic     slot_we;
   logic     slot_re;
   logic [SLOT_ADDR_W-1:0] slot_waddr, slot_raddr;
   slot_type slot_wdata;

   req_type req_ff;
   logic [WIN_W-1:0]      ws_ff;
   logic [SEQ_BITS-1:0]   ns_ff, ns_in;
   logic [MAX_WINDOW-1:0] sv_ff, sv_in;

   // One released item is kept back so that the final one can carry last.
   logic                   pend_valid_ff, pend_valid_in;
   logic [HANDLE_BITS-1:0] pend_handle_ff, pend_handle_in;

   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   logic                   emit_en;
   logic                   emit_fwd;
   logic [HANDLE_BITS-1:0] emit_handle;

   logic                   accept;
   logic                   tid_ok;
   logic                   started;
   logic [SEQ_BITS-1:0]    base_seq;
   logic [MAX_WINDOW-1:0]  base_sv;
   logic [SEQ_BITS-1:0]    seq_off;
   logic [SEQ_BITS-1:0]    ws_eff;
   logic [SLOT_BITS-1:0]   seq_slot;
   logic [SLOT_BITS-1:0]   drain_slot;
   logic [TID_BITS-1:0]    cur_tid;

   assign accept     = start && (state_ff == ST_IDLE);
   assign tid_ok     = (32'(req.tid) < NUM_TIDS);
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   assign cur_tid    = req_ff.tid[TID_BITS-1:0];
   assign seq_slot   = req_ff.seq[SLOT_BITS-1:0];
   assign drain_slot = ns_ff[SLOT_BITS-1:0];

   // The first frame of a session opens the window at its own sequence number.
   assign started  = ctx_valid_ff[cur_tid];
   assign base_seq = started ? ctx_q_ff.next_seq : req_ff.seq;
   assign base_sv  = started ? ctx_q_ff.slot_valid : '0;
   assign seq_off  = req_ff.seq - base_seq;

   // A window of zero behaves as one, and one above the slot count as the slot count.
   always_comb begin
      if (ws_ff == '0) begin
         ws_eff = SEQ_BITS'(1);
      end else if (32'(ws_ff) > MAX_WINDOW) begin
         ws_eff = SEQ_BITS'(MAX_WINDOW);
      end else begin
         ws_eff = SEQ_BITS'(ws_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      ns_in          = ns_ff;
      sv_in          = sv_ff;
      ctx_valid_in   = ctx_valid_ff;
      ctx_we         = 1'b0;
      ctx_wdata      = '{next_seq: ns_ff, slot_valid: sv_ff};
      slot_we        = 1'b0;
      slot_waddr     = {cur_tid, seq_slot};
      slot_wdata     = '{handle: req_ff.frame_handle, forward: req_ff.forward};
      slot_re        = 1'b0;
      slot_raddr     = {cur_tid, drain_slot};
      emit_en        = 1'b0;
      emit_fwd       = req_ff.forward;
      emit_handle    = req_ff.frame_handle;

      case (state_ff)
         ST_IDLE: begin
            if (accept && tid_ok) begin
               if (req.kind == KIND_SESSION) begin
                  ctx_valid_in[req.tid[TID_BITS-1:0]] = 1'b0;
               end else begin
                  state_in = ST_CTX;
               end
            end
         end
         ST_CTX: begin
            if (seq_off[SEQ_BITS-1]) begin
               // Old frame: nothing changes.
               state_in = ST_IDLE;
            end else if (seq_off == '0) begin
               emit_en  = 1'b1;
               ns_in    = base_seq + SEQ_BITS'(1);
               sv_in    = base_sv;
               state_in = ST_DRAIN;
            end else if (seq_off < ws_eff) begin
               state_in = ST_IDLE;
               if (!base_sv[seq_slot]) begin
                  ctx_we    = 1'b1;
                  ctx_wdata = '{next_seq: base_seq,
                                slot_valid: base_sv | (MAX_WINDOW'(1) << seq_slot)};
                  slot_we   = 1'b1;
               end
            end else begin
               // Beyond the window: drop the held frames, release this one and restart after it.
               emit_en   = 1'b1;
               ctx_we    = 1'b1;
               ctx_wdata = '{next_seq: req_ff.seq + SEQ_BITS'(1), slot_valid: '0};
               state_in  = ST_FLUSH;
            end
         end
         ST_DRAIN: begin
            if (sv_ff[drain_slot]) begin
               sv_in[drain_slot] = 1'b0;
               slot_re           = 1'b1;
               state_in          = ST_SLOT;
            end else begin
               ctx_we   = 1'b1;
               state_in = ST_FLUSH;
            end
         end
         ST_SLOT: begin
            emit_en     = 1'b1;
            emit_fwd    = slot_q_ff.forward;
            emit_handle = slot_q_ff.handle;
            ns_in       = ns_ff + SEQ_BITS'(1);
            state_in    = ST_DRAIN;
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ctx_we) begin
         ctx_valid_in[cur_tid] = 1'b1;
      end
   end

   // Output side: a newly released frame pushes out the one kept back, and the
   // flush step sends the kept one as the final item.
   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_handle_in = pend_handle_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = '{out_handle: pend_handle_ff, out_tid: req_ff.tid, last: 1'b0};

      if (emit_en && emit_fwd) begin
         rsp_strobe_in  = pend_valid_ff;
         pend_valid_in  = 1'b1;
         pend_handle_in = emit_handle;
      end else if (state_ff == ST_FLUSH) begin
         rsp_strobe_in = pend_valid_ff;
         rsp_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ctx_valid_ff  <= '0;
         ws_ff         <= WIN_W'(WIN_RESET);
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ctx_valid_ff  <= ctx_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            ws_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
      ns_ff          <= ns_in;
      sv_ff          <= sv_in;
      pend_handle_ff <= pend_handle_in;
      rsp_ff         <= rsp_in;
   end

   // Context memory: read on acceptance, written back at the end of the item.
   always_ff @(posedge clock) begin
      if (ctx_we) begin
         ctx_mem[cur_tid] <= ctx_wdata;
      end
      if (accept) begin
         ctx_q_ff <= ctx_mem[req.tid[TID_BITS-1:0]];
      end
   end

   // Slot memory: written when a frame is held, read once per drained frame.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_q_ff <= slot_mem[slot_raddr];
      end
   end

endmodule
